### sv/htc_pkg.sv
// Package for the HSV threshold centroid block: types, constants and HSV helpers.
`timescale 1ns / 1ps
package htc_pkg;
	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_DIV,
		ST_FLUSH
	} state_t;

	typedef enum logic [2:0] {
		REG_HUE_LOW   = 3'd0,
		REG_HUE_HIGH  = 3'd1,
		REG_SAT_LOW   = 3'd2,
		REG_SAT_HIGH  = 3'd3,
		REG_VAL_LOW   = 3'd4,
		REG_VAL_HIGH  = 3'd5,
		REG_FRAME_W   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  hue_low;
		logic [7:0]  hue_high;
		logic [7:0]  sat_low;
		logic [7:0]  sat_high;
		logic [7:0]  val_low;
		logic [7:0]  val_high;
		logic [12:0] frame_width;
	} cfg_t;

	typedef struct packed {
		logic take;
		logic last;
		logic div_start;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic last_done;
		logic div_done;
	} sts_t;

	function automatic logic [19:0] recip_div(input logic [19:0] num, input logic [19:0] den);
		logic [19:0] q;
		logic [20:0] rem;
		q = '0;
		rem = '0;
		for (int i = 19; i >= 0; i--) begin
			rem = {rem[19:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [5119:0] sat_tab_build();
		logic [5119:0] t;
		logic [19:0] m;
		t = '0;
		for (int i = 1; i < 256; i++) begin
			m = 20'(i);
			t[i*20 +: 20] = recip_div(20'd1044480 + {1'b0, m[19:1]}, m);
		end
		return t;
	endfunction

	function automatic logic [5119:0] hue_tab_build();
		logic [5119:0] t;
		logic [19:0] m;
		t = '0;
		for (int i = 1; i < 256; i++) begin
			m = 20'(i);
			t[i*20 +: 20] = recip_div(20'd737280 + 20'd3 * m, 20'd6 * m);
		end
		return t;
	endfunction

	localparam logic [5119:0] SAT_TAB = sat_tab_build();
	localparam logic [5119:0] HUE_TAB = hue_tab_build();

	function automatic logic [19:0] sat_recip(input logic [7:0] mx);
		return SAT_TAB[20*mx +: 20];
	endfunction

	function automatic logic [19:0] hue_recip(input logic [7:0] d);
		return HUE_TAB[20*d +: 20];
	endfunction
endpackage

### sv/hsv_threshold_centroid_x_core.sv
// Top level of the HSV threshold centroid block.
// Pixels (blue, green, red, frame_end) enter by in_valid/in_stall; one transfer
// per clock while a frame runs. Each pixel goes through a two-stage HSV and
// threshold pipeline into column, count and sum accumulators.
// On the frame-end transfer in_stall rises at once and holds while the pipeline
// drains and a restoring divider forms floor(sum/count), one quotient bit a
// cycle over the sum width (36 bits at the default sizes). out_valid rises
// in the cycle in which in_stall falls, and the next pixel can transfer in that
// same cycle at the soonest.
// The result (ball_column, found) sits in an output register; while out_stall
// holds it, the next frame runs on, and a further frame end waits in the
// divider, with in_stall high, until the register frees.
// Registers are written over the APB port at 4*index; reads return them.
// Reset clears the accumulators, column counter and output valid, and loads
// the register reset values.
`timescale 1ns / 1ps
module hsv_threshold_centroid_x_core #(
	parameter int MAX_WIDTH  = htc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = htc_pkg::MAX_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  blue,
	input  logic [7:0]  green,
	input  logic [7:0]  red,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] ball_column,
	output logic        found
);
	import htc_pkg::*;
	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic [2:0] ridx;
	assign ridx = paddr[4:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{8'd0, 8'd10, 8'd120, 8'd255, 8'd70, 8'd255, 13'd800};
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_HUE_LOW:  cfg_q.hue_low <= pwdata[7:0];
				REG_HUE_HIGH: cfg_q.hue_high <= pwdata[7:0];
				REG_SAT_LOW:  cfg_q.sat_low <= pwdata[7:0];
				REG_SAT_HIGH: cfg_q.sat_high <= pwdata[7:0];
				REG_VAL_LOW:  cfg_q.val_low <= pwdata[7:0];
				REG_VAL_HIGH: cfg_q.val_high <= pwdata[7:0];
				REG_FRAME_W:  cfg_q.frame_width <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_HUE_LOW:  prdata = {24'd0, cfg_q.hue_low};
			REG_HUE_HIGH: prdata = {24'd0, cfg_q.hue_high};
			REG_SAT_LOW:  prdata = {24'd0, cfg_q.sat_low};
			REG_SAT_HIGH: prdata = {24'd0, cfg_q.sat_high};
			REG_VAL_LOW:  prdata = {24'd0, cfg_q.val_low};
			REG_VAL_HIGH: prdata = {24'd0, cfg_q.val_high};
			REG_FRAME_W:  prdata = {19'd0, cfg_q.frame_width};
			default:      prdata = 32'd0;
		endcase
	end

	htc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_frame_end(frame_end),
		.out_stall(out_stall), .sts(sts), .cmd(cmd), .in_stall(in_stall),
		.out_valid(out_valid)
	);

	htc_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .cmd(cmd),
		.blue(blue), .green(green), .red(red), .sts(sts),
		.ball_column(ball_column), .found(found)
	);
endmodule

### sv/htc_ctrl.sv
// Controller for the HSV threshold centroid block: frame-end division sequence.
`timescale 1ns / 1ps
module htc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_frame_end,
	input  logic          out_stall,
	input  htc_pkg::sts_t sts,
	output htc_pkg::cmd_t cmd,
	output logic          in_stall,
	output logic          out_valid
);
	import htc_pkg::*;
	state_t state_q, state_d;
	logic out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: if (in_valid && in_frame_end) state_d = ST_FLUSH;
			ST_FLUSH: if (sts.last_done) state_d = ST_DIV;
			ST_DIV: if (sts.div_done && !(out_valid_q && out_stall)) state_d = ST_RUN;
			default: state_d = ST_RUN;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_RUN: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
				cmd.last = in_frame_end;
			end
			ST_FLUSH: begin
				cmd.div_start = sts.last_done;
			end
			ST_DIV: begin
				cmd.div_step = !sts.div_done;
				cmd.out_load = sts.div_done && !(out_valid_q && out_stall);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end
	assign out_valid = out_valid_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall)) else $error("result overwritten");
	a_no_take_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_RUN |-> !cmd.take) else $error("pixel taken outside a frame run");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q) else $error("result dropped");
endmodule

### sv/htc_datapath.sv
// Datapath for the HSV threshold centroid block: HSV pipeline, accumulators, divider.
`timescale 1ns / 1ps
module htc_datapath #(
	parameter int MAX_WIDTH  = htc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = htc_pkg::MAX_HEIGHT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  htc_pkg::cfg_t cfg,
	input  htc_pkg::cmd_t cmd,
	input  logic [7:0]    blue,
	input  logic [7:0]    green,
	input  logic [7:0]    red,
	output htc_pkg::sts_t sts,
	output logic [11:0]   ball_column,
	output logic          found
);
	import htc_pkg::*;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam longint CNT_MAX = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
	localparam longint SUM_MAX = CNT_MAX * longint'(MAX_WIDTH - 1);
	localparam int NW = $clog2(CNT_MAX + 1);
	localparam int SW = $clog2(SUM_MAX + 1);
	localparam int DCW = $clog2(SW + 1);

	// stage 1: max, min, reciprocals
	logic        v1_s1, last_s1;
	logic [7:0]  mx_s1, diff_s1, mn;
	logic [19:0] srec_s1, hrec_s1;
	logic signed [11:0] hp_s1;
	logic [7:0]  mx;
	always_comb begin
		mx = red; mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
	end
	logic [7:0] df;
	assign df = mx - mn;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else begin
			v1_s1 <= cmd.take;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			last_s1 <= cmd.last;
			mx_s1 <= mx;
			diff_s1 <= df;
			srec_s1 <= sat_recip(mx);
			hrec_s1 <= hue_recip(df);
			if (mx == red)
				hp_s1 <= 12'(signed'({4'd0, green}) - signed'({4'd0, blue}));
			else if (mx == green)
				hp_s1 <= 12'(signed'({4'd0, blue}) - signed'({4'd0, red})
					+ signed'({3'd0, df, 1'b0}));
			else
				hp_s1 <= 12'(signed'({4'd0, red}) - signed'({4'd0, green})
					+ signed'({2'd0, df, 2'b0}));
		end
	end

	// stage 2: products and match
	logic        v_s2, last_s2, m_s2;
	logic [19:0] sp;
	logic signed [31:0] hprod;
	logic [7:0]  s_v, h_v;
	logic [12:0] hq;
	always_comb begin
		sp = {12'd0, diff_s1} * srec_s1 + 20'd2048;
		s_v = sp[19:12];
		hprod = 32'(hp_s1) * signed'({12'd0, hrec_s1}) + 32'sd2048 + 32'sd1048576;
		hq = hprod[24:12] - 13'd256;
		h_v = hq[12] ? 8'(hq + 13'd180) : hq[7:0];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v1_s1;
	end
	always_ff @(posedge clk) begin
		last_s2 <= last_s1;
		m_s2 <= h_v >= cfg.hue_low && h_v <= cfg.hue_high
			&& s_v >= cfg.sat_low && s_v <= cfg.sat_high
			&& mx_s1 >= cfg.val_low && mx_s1 <= cfg.val_high;
	end

	// accumulators
	logic [CW-1:0] col_q;
	logic [NW-1:0] cnt_q;
	logic [SW-1:0] sum_q;
	logic [SW:0]   sum_n;
	logic [13:0]   wid;
	logic          last_q;
	assign wid = (cfg.frame_width == 13'd0 || 32'(cfg.frame_width) > MAX_WIDTH)
		? 14'(MAX_WIDTH) : {1'b0, cfg.frame_width};
	assign sum_n = {1'b0, sum_q} + (SW + 1)'(col_q);

	// divider
	logic [SW-1:0] quo_q;
	logic [NW:0]   rem_q;
	logic [DCW-1:0] dcnt_q;
	logic [NW:0]   rtry;
	logic          div_done;
	assign rtry = {rem_q[NW-1:0], quo_q[SW-1]};
	assign div_done = (dcnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0; cnt_q <= '0; sum_q <= '0; last_q <= 1'b0; dcnt_q <= '0;
		end else begin
			last_q <= v_s2 && last_s2;
			if (v_s2) begin
				if (m_s2) begin
					if (64'(cnt_q) < CNT_MAX) cnt_q <= cnt_q + 1'b1;
					sum_q <= (64'(sum_n) > SUM_MAX) ? SW'(SUM_MAX) : sum_n[SW-1:0];
				end
				if (15'(col_q) + 15'd1 >= 15'(wid)) col_q <= '0;
				else col_q <= col_q + 1'b1;
			end
			if (cmd.div_start) begin
				dcnt_q <= DCW'(SW);
				col_q <= '0;
			end else if (cmd.div_step) dcnt_q <= dcnt_q - 1'b1;
			if (cmd.out_load) begin
				cnt_q <= '0; sum_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q <= sum_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (rtry >= {1'b0, cnt_q}) begin
				rem_q <= rtry - {1'b0, cnt_q};
				quo_q <= {quo_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= rtry;
				quo_q <= {quo_q[SW-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			found <= cnt_q != '0;
			if (cnt_q == '0) ball_column <= 12'd0;
			else if (64'(quo_q) > 64'(MAX_WIDTH - 1)) ball_column <= 12'(MAX_WIDTH - 1);
			else ball_column <= 12'(quo_q);
		end
	end

	assign sts = {last_q, div_done};

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		15'(col_q) < 15'(wid)) else $error("column out of range");
	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		64'(cnt_q) <= CNT_MAX) else $error("count beyond saturation");
	a_sum_sat: assert property (@(posedge clk) disable iff (!arst_n)
		64'(sum_q) <= SUM_MAX) else $error("sum beyond saturation");
endmodule

### sim/hsv_centroid_checker.sv
// Checker for the HSV threshold centroid block: predicts frame results and compares them.
`timescale 1ns / 1ps
module hsv_centroid_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  blue,
	input  logic [7:0]  green,
	input  logic [7:0]  red,
	input  logic        frame_end,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [11:0] ball_column,
	input  logic        found,
	output int          fail_count,
	output int          pending
);
	import htc_pkg::*;

	localparam longint COUNT_MAX = 64'd4096 * 64'd4096;
	localparam longint SUM_MAX = COUNT_MAX * 64'd4095;

	typedef struct packed {
		logic [11:0] column;
		logic        hit;
	} centroid_t;

	logic [7:0]  thr_hue_lo, thr_hue_hi, thr_sat_lo, thr_sat_hi, thr_val_lo, thr_val_hi;
	logic [12:0] row_width;
	int unsigned col_pos;
	longint unsigned hit_count, col_total;
	centroid_t centroid_q[$];

	assign pending = centroid_q.size();

	function automatic void pixel_hsv(input int b, input int g, input int r,
		output int h, output int s, output int v);
		int mx, mn, diff, sdiv, hdiv, hp, prod;
		mx = r; mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		diff = mx - mn;
		v = mx;
		sdiv = mx ? (255 * 4096 + mx / 2) / mx : 0;
		s = (diff * sdiv + 2048) >>> 12;
		hdiv = diff ? (180 * 4096 + 3 * diff) / (6 * diff) : 0;
		if (mx == r)
			hp = g - b;
		else if (mx == g)
			hp = b - r + 2 * diff;
		else
			hp = r - g + 4 * diff;
		prod = hp * hdiv + 2048;
		hp = ((prod + 1048576) >>> 12) - 256;
		if (hp < 0) hp += 180;
		h = hp;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int h, s, v;
		int unsigned w;
		int errs;
		longint unsigned mean;
		centroid_t got, want;
		if (!arst_n) begin
			thr_hue_lo <= 8'd0; thr_hue_hi <= 8'd10;
			thr_sat_lo <= 8'd120; thr_sat_hi <= 8'd255;
			thr_val_lo <= 8'd70; thr_val_hi <= 8'd255;
			row_width <= 13'd800;
			col_pos = 0; hit_count = 0; col_total = 0;
			fail_count <= 0;
			centroid_q.delete();
		end else begin
			errs = 0;
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_HUE_LOW:  thr_hue_lo <= pwdata[7:0];
					REG_HUE_HIGH: thr_hue_hi <= pwdata[7:0];
					REG_SAT_LOW:  thr_sat_lo <= pwdata[7:0];
					REG_SAT_HIGH: thr_sat_hi <= pwdata[7:0];
					REG_VAL_LOW:  thr_val_lo <= pwdata[7:0];
					REG_VAL_HIGH: thr_val_hi <= pwdata[7:0];
					REG_FRAME_W:  row_width <= pwdata[12:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				pixel_hsv(int'(blue), int'(green), int'(red), h, s, v);
				if (h >= thr_hue_lo && h <= thr_hue_hi && s >= thr_sat_lo &&
					s <= thr_sat_hi && v >= thr_val_lo && v <= thr_val_hi) begin
					if (hit_count < COUNT_MAX) hit_count++;
					col_total += 64'(col_pos);
					if (col_total > SUM_MAX) col_total = SUM_MAX;
				end
				w = 32'(row_width);
				if (w == 0 || w > 4096) w = 4096;
				col_pos++;
				if (col_pos >= w) col_pos = 0;
				if (frame_end) begin
					if (hit_count != 0) begin
						mean = col_total / hit_count;
						if (mean > 4095) mean = 4095;
						want.column = mean[11:0];
						want.hit = 1'b1;
					end else begin
						want = '0;
					end
					centroid_q.push_back(want);
					col_pos = 0; hit_count = 0; col_total = 0;
				end
			end
			if (out_valid && !out_stall) begin
				got.column = ball_column;
				got.hit = found;
				if (centroid_q.size() == 0) begin
					$error("unexpected result: ball_column %0d found %0d", ball_column, found);
					errs++;
				end else begin
					want = centroid_q.pop_front();
					if (got.column !== want.column) begin
						$error("ball_column: expected %0d, actual %0d", want.column, got.column);
						errs++;
					end
					if (got.hit !== want.hit) begin
						$error("found: expected %0d, actual %0d", want.hit, got.hit);
						errs++;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
		end
	end
endmodule

### sim/testbench.sv
// Testbench top: drives pixels and register writes into the centroid block, gives the verdict.
`timescale 1ns / 1ps
module testbench;
	import htc_pkg::*;

	logic        clk, arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        in_valid, in_stall;
	logic [7:0]  blue, green, red;
	logic        frame_end;
	logic        out_valid, out_stall;
	logic [11:0] ball_column;
	logic        found;
	int          fail_count, pending;
	int          send_idle, recv_idle;
	bit          hold_off;

	hsv_threshold_centroid_x_core DUT (.*);
	hsv_centroid_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("** hsv_threshold_centroid_x_core: FAILED **");
		$finish;
	end

	// receiver stall: random, or a long hold-off
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= hold_off || ($urandom_range(99) < recv_idle);
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic pixel_send(input logic [7:0] b, input logic [7:0] g,
		input logic [7:0] r, input logic last);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		blue <= b; green <= g; red <= r; frame_end <= last;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic pixel_idle();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		int n;
		pixel_idle();
		n = 0;
		while (pending != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (80) @(posedge clk);
	endtask

	// frame of random pixels, a hue_bias percentage of them biased towards red
	task automatic random_frame(input int len, input int hue_bias);
		logic [7:0] b, g, r;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom); g = 8'($urandom); r = 8'($urandom);
			if ($urandom_range(99) < hue_bias) begin
				r = 8'($urandom_range(255, 100));
				g = 8'($urandom_range(30));
				b = 8'($urandom_range(30));
			end
			pixel_send(b, g, r, i == len - 1);
		end
	endtask

	task automatic random_config(input bit wide_open);
		logic [7:0] a, c;
		a = 8'($urandom); c = 8'($urandom);
		reg_write(REG_HUE_LOW, wide_open ? 0 : $urandom_range(20));
		reg_write(REG_HUE_HIGH, wide_open ? 179 : $urandom_range(179, 5));
		reg_write(REG_SAT_LOW, wide_open ? 0 : (a < c ? a : c));
		reg_write(REG_SAT_HIGH, wide_open ? 255 : (a < c ? c : a));
		reg_write(REG_VAL_LOW, $urandom_range(wide_open ? 0 : 80));
		reg_write(REG_VAL_HIGH, {$urandom_range(255, 128)} | 32'hFFFFFF00);
		reg_write(REG_FRAME_W, $urandom_range(9, 1));
	endtask

	initial begin
		int items;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; blue = '0; green = '0; red = '0; frame_end = 1'b0;
		send_idle = 0; recv_idle = 0; hold_off = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds: red, black, grey, ties, extremes
		pixel_send(8'd0, 8'd0, 8'd255, 1'b0);
		pixel_send(8'd0, 8'd0, 8'd0, 1'b0);
		pixel_send(8'd128, 8'd128, 8'd128, 1'b0);
		pixel_send(8'd255, 8'd255, 8'd255, 1'b0);
		pixel_send(8'd10, 8'd20, 8'd200, 1'b0);
		pixel_send(8'd255, 8'd0, 8'd255, 1'b0);
		pixel_send(8'd0, 8'd255, 8'd255, 1'b0);
		pixel_send(8'd0, 8'd0, 8'd200, 1'b1);
		pixel_send(8'd0, 8'd255, 8'd0, 1'b1);
		drain();
		// full range, tiny width, wrap
		reg_write(REG_HUE_LOW, 0); reg_write(REG_HUE_HIGH, 179);
		reg_write(REG_SAT_LOW, 0); reg_write(REG_SAT_HIGH, 255);
		reg_write(REG_VAL_LOW, 0); reg_write(REG_VAL_HIGH, 255);
		reg_write(REG_FRAME_W, 3);
		pixel_send(8'd255, 8'd0, 8'd0, 1'b0);
		pixel_send(8'd0, 8'd255, 8'd0, 1'b0);
		pixel_send(8'd255, 8'd255, 8'd0, 1'b0);
		pixel_send(8'd1, 8'd2, 8'd3, 1'b0);
		pixel_send(8'd0, 8'd255, 8'd255, 1'b1);
		drain();
		// inverted range and bad widths
		reg_write(REG_HUE_LOW, 179); reg_write(REG_HUE_HIGH, 0);
		reg_write(REG_FRAME_W, 0);
		pixel_send(8'd0, 8'd0, 8'd255, 1'b0);
		pixel_send(8'd0, 8'd0, 8'd255, 1'b1);
		drain();
		reg_write(REG_HUE_LOW, 0); reg_write(REG_HUE_HIGH, 179);
		reg_write(REG_FRAME_W, 32'h1FFF);
		pixel_send(8'd9, 8'd99, 8'd199, 1'b0);
		pixel_send(8'd99, 8'd9, 8'd199, 1'b1);
		drain();
		reg_write(REG_FRAME_W, 4096);
		pixel_send(8'd200, 8'd100, 8'd50, 1'b1);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 17 : (ph == 1) ? 80 : 0;
			recv_idle = (ph == 0) ? 80 : (ph == 1) ? 17 : 0;
			random_config(ph == 2);
			items = 0;
			while (items < 130) begin
				int len;
				len = $urandom_range(12, 1);
				random_frame(len, 50);
				items += len;
			end
			drain();
		end

		// long hold-off on the receiver while many short frames arrive
		reg_write(REG_FRAME_W, 4);
		hold_off = 1'b1;
		fork
			begin
				for (int i = 0; i < 300; i++) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 12; i++) random_frame(2, 60);
		join
		drain();

		if (fail_count == 0 && pending == 0)
			$display("** hsv_threshold_centroid_x_core: PASSED **");
		else
			$display("** hsv_threshold_centroid_x_core: FAILED **");
		$finish;
	end
endmodule

### filelist.f
sv/htc_pkg.sv
sv/htc_ctrl.sv
sv/htc_datapath.sv
sv/hsv_threshold_centroid_x_core.sv
sim/hsv_centroid_checker.sv
sim/testbench.sv
